// File: sv/sbot_pkg.sv
// ----------------------------------------------------------------------------
// sbot_pkg
// shared constants and types for the segment versus box overlap pipeline
// ----------------------------------------------------------------------------
package sbot_pkg;

    // spatial axes
    localparam int unsigned NUM_AXES = 3;

    // configuration register file
    localparam int unsigned NUM_REGS  = 6;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BOX_LOWER_X = 3'd0;
    localparam t_cfg_idx REG_BOX_UPPER_X = 3'd1;
    localparam t_cfg_idx REG_BOX_LOWER_Y = 3'd2;
    localparam t_cfg_idx REG_BOX_UPPER_Y = 3'd3;
    localparam t_cfg_idx REG_BOX_LOWER_Z = 3'd4;
    localparam t_cfg_idx REG_BOX_UPPER_Z = 3'd5;

    // axis pairs for the cross-product axes (direction x box axis)
    typedef logic [1:0] t_axis_idx;

    localparam t_axis_idx CROSS_I [NUM_AXES] = '{2'd1, 2'd2, 2'd0};
    localparam t_axis_idx CROSS_J [NUM_AXES] = '{2'd2, 2'd0, 2'd1};

    // result stream
    localparam int unsigned M_TDATA_W = 8;

    // pipeline depth (stage registers, output register included)
    localparam int unsigned NUM_STAGES = 5;

endpackage

// File: sv/sbot_prep.sv
// ----------------------------------------------------------------------------
// sbot_prep
// first two pipeline stages: doubled extents, directions and centre offsets
// ----------------------------------------------------------------------------
module sbot_prep #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  logic signed [COORD_BITS-1:0]  i_start [sbot_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  i_end   [sbot_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  i_lower [sbot_pkg::NUM_AXES],
    input  logic signed [COORD_BITS-1:0]  i_upper [sbot_pkg::NUM_AXES],
    output logic signed [COORD_BITS:0]    o_d     [sbot_pkg::NUM_AXES],
    output logic signed [COORD_BITS:0]    o_e     [sbot_pkg::NUM_AXES],
    output logic signed [COORD_BITS+1:0]  o_t     [sbot_pkg::NUM_AXES],
    output logic signed [COORD_BITS+1:0]  o_absd  [sbot_pkg::NUM_AXES]
);

    localparam int unsigned W1 = COORD_BITS + 1;
    localparam int unsigned W2 = COORD_BITS + 2;

    logic signed [W1-1:0] r1_d [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] r1_m [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] r1_e [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] r1_c [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] n1_d [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] n1_m [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] n1_e [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] n1_c [sbot_pkg::NUM_AXES];

    logic signed [W1-1:0] r2_d    [sbot_pkg::NUM_AXES];
    logic signed [W1-1:0] r2_e    [sbot_pkg::NUM_AXES];
    logic signed [W2-1:0] r2_t    [sbot_pkg::NUM_AXES];
    logic signed [W2-1:0] r2_absd [sbot_pkg::NUM_AXES];
    logic signed [W2-1:0] n2_t    [sbot_pkg::NUM_AXES];
    logic signed [W2-1:0] n2_absd [sbot_pkg::NUM_AXES];

    // stage 1: direction, doubled midpoint, full extent, doubled centre
    always_comb begin
        for (int a = 0; a < sbot_pkg::NUM_AXES; a++) begin
            n1_d[a] = W1'(i_end[a])   - W1'(i_start[a]);
            n1_m[a] = W1'(i_end[a])   + W1'(i_start[a]);
            n1_e[a] = W1'(i_upper[a]) - W1'(i_lower[a]);
            n1_c[a] = W1'(i_upper[a]) + W1'(i_lower[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_d <= n1_d;
            r1_m <= n1_m;
            r1_e <= n1_e;
            r1_c <= n1_c;
        end
    end

    // stage 2: centre offset and direction magnitude
    always_comb begin
        logic signed [W2-1:0] d_ext;
        for (int a = 0; a < sbot_pkg::NUM_AXES; a++) begin
            n2_t[a]    = W2'(r1_m[a]) - W2'(r1_c[a]);
            d_ext      = W2'(r1_d[a]);
            n2_absd[a] = d_ext[W2-1] ? -d_ext : d_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_d    <= r1_d;
            r2_e    <= r1_e;
            r2_t    <= n2_t;
            r2_absd <= n2_absd;
        end
    end

    assign o_d    = r2_d;
    assign o_e    = r2_e;
    assign o_t    = r2_t;
    assign o_absd = r2_absd;

endmodule

// File: sv/sbot_mul.sv
// ----------------------------------------------------------------------------
// sbot_mul
// third pipeline stage: box-axis tests and the cross-axis products
// ----------------------------------------------------------------------------
module sbot_mul #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [COORD_BITS:0]     i_d     [sbot_pkg::NUM_AXES],
    input  logic signed [COORD_BITS:0]     i_e     [sbot_pkg::NUM_AXES],
    input  logic signed [COORD_BITS+1:0]   i_t     [sbot_pkg::NUM_AXES],
    input  logic signed [COORD_BITS+1:0]   i_absd  [sbot_pkg::NUM_AXES],
    output logic                           o_axis_sep,
    output logic signed [2*COORD_BITS+2:0] o_pa    [sbot_pkg::NUM_AXES],
    output logic signed [2*COORD_BITS+2:0] o_pb    [sbot_pkg::NUM_AXES],
    output logic signed [2*COORD_BITS+2:0] o_pe    [sbot_pkg::NUM_AXES],
    output logic signed [2*COORD_BITS+2:0] o_pf    [sbot_pkg::NUM_AXES]
);

    localparam int unsigned W3 = COORD_BITS + 3;
    localparam int unsigned PW = 2 * COORD_BITS + 3;

    logic                 r_axis_sep;
    logic                 n_axis_sep;
    logic signed [PW-1:0] r_pa [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] r_pb [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] r_pe [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] r_pf [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] n_pa [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] n_pb [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] n_pe [sbot_pkg::NUM_AXES];
    logic signed [PW-1:0] n_pf [sbot_pkg::NUM_AXES];

    // |t| > e + |d| on each box axis
    always_comb begin
        logic signed [W3-1:0] t_ext;
        logic signed [W3-1:0] abs_t;
        logic signed [W3-1:0] reach;
        n_axis_sep = 1'b0;
        for (int a = 0; a < sbot_pkg::NUM_AXES; a++) begin
            t_ext = W3'(i_t[a]);
            abs_t = t_ext[W3-1] ? -t_ext : t_ext;
            reach = W3'(i_e[a]) + W3'(i_absd[a]);
            if (abs_t > reach) begin
                n_axis_sep = 1'b1;
            end
        end
    end

    // cross axis k pairs axes i and j:
    // lhs = d_i t_j - d_j t_i, rhs = e_i |d_j| + e_j |d_i|
    always_comb begin
        for (int k = 0; k < sbot_pkg::NUM_AXES; k++) begin
            n_pa[k] = PW'(i_d[sbot_pkg::CROSS_I[k]]) * PW'(i_t[sbot_pkg::CROSS_J[k]]);
            n_pb[k] = PW'(i_d[sbot_pkg::CROSS_J[k]]) * PW'(i_t[sbot_pkg::CROSS_I[k]]);
            n_pe[k] = PW'(i_e[sbot_pkg::CROSS_I[k]]) * PW'(i_absd[sbot_pkg::CROSS_J[k]]);
            n_pf[k] = PW'(i_e[sbot_pkg::CROSS_J[k]]) * PW'(i_absd[sbot_pkg::CROSS_I[k]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axis_sep <= n_axis_sep;
            r_pa       <= n_pa;
            r_pb       <= n_pb;
            r_pe       <= n_pe;
            r_pf       <= n_pf;
        end
    end

    assign o_axis_sep = r_axis_sep;
    assign o_pa       = r_pa;
    assign o_pb       = r_pb;
    assign o_pe       = r_pe;
    assign o_pf       = r_pf;

endmodule

// File: sv/sbot_dec.sv
// ----------------------------------------------------------------------------
// sbot_dec
// last two pipeline stages: cross-axis sums, compares and the hit decision
// ----------------------------------------------------------------------------
module sbot_dec #(
    parameter int unsigned COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic [1:0]                     i_en,
    input  logic                           i_axis_sep,
    input  logic signed [2*COORD_BITS+2:0] i_pa [sbot_pkg::NUM_AXES],
    input  logic signed [2*COORD_BITS+2:0] i_pb [sbot_pkg::NUM_AXES],
    input  logic signed [2*COORD_BITS+2:0] i_pe [sbot_pkg::NUM_AXES],
    input  logic signed [2*COORD_BITS+2:0] i_pf [sbot_pkg::NUM_AXES],
    output logic                           o_hit
);

    localparam int unsigned LW = 2 * COORD_BITS + 4;

    logic                 r_axis_sep;
    logic signed [LW-1:0] r_lhs [sbot_pkg::NUM_AXES];
    logic signed [LW-1:0] r_rhs [sbot_pkg::NUM_AXES];
    logic signed [LW-1:0] n_lhs [sbot_pkg::NUM_AXES];
    logic signed [LW-1:0] n_rhs [sbot_pkg::NUM_AXES];
    logic                 r_hit;
    logic                 n_hit;

    // stage 4: signed cross term and its bound
    always_comb begin
        for (int k = 0; k < sbot_pkg::NUM_AXES; k++) begin
            n_lhs[k] = LW'(i_pa[k]) - LW'(i_pb[k]);
            n_rhs[k] = LW'(i_pe[k]) + LW'(i_pf[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_axis_sep <= i_axis_sep;
            r_lhs      <= n_lhs;
            r_rhs      <= n_rhs;
        end
    end

    // stage 5: any separating axis clears the hit
    always_comb begin
        logic signed [LW-1:0] abs_lhs;
        logic                 sep;
        sep = r_axis_sep;
        for (int k = 0; k < sbot_pkg::NUM_AXES; k++) begin
            abs_lhs = r_lhs[k][LW-1] ? -r_lhs[k] : r_lhs[k];
            if (abs_lhs > r_rhs[k]) begin
                sep = 1'b1;
            end
        end
        n_hit = ~sep;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// File: sv/segment_box_overlap_test_top.sv
// ----------------------------------------------------------------------------
// segment_box_overlap_test_top
// segment versus axis-aligned box overlap, separating axis test per segment
// ----------------------------------------------------------------------------
// throughput: one segment per cycle; stages advance independently, so a
//   stalled result only holds the stages behind it that are occupied
// reset: i_rst_n synchronous active low; clears the stage valid bits and
//   sets all six box registers to zero
// ----------------------------------------------------------------------------
module segment_box_overlap_test_top #(
    parameter  int unsigned COORD_BITS = 24,
    localparam int unsigned S_TDATA_W  = ((6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // segment stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z (lowest first)
    input  logic [S_TDATA_W-1:0]                s_axis_tdata,

    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit in bit 0, upper bits zero
    output logic [sbot_pkg::M_TDATA_W-1:0]      m_axis_tdata,

    // box register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [COORD_BITS-1:0]               i_cfg_data
);

    localparam int unsigned NS = sbot_pkg::NUM_STAGES;

    // box registers, lower/upper per axis
    logic signed [COORD_BITS-1:0] r_lower [sbot_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] r_upper [sbot_pkg::NUM_AXES];

    // per-stage valid bits and advance enables
    logic [NS-1:0] r_vld;
    logic [NS-1:0] stage_en;

    // unpacked segment endpoints
    logic signed [COORD_BITS-1:0] seg_start [sbot_pkg::NUM_AXES];
    logic signed [COORD_BITS-1:0] seg_end   [sbot_pkg::NUM_AXES];

    // inter-stage payload
    logic signed [COORD_BITS:0]     p_d    [sbot_pkg::NUM_AXES];
    logic signed [COORD_BITS:0]     p_e    [sbot_pkg::NUM_AXES];
    logic signed [COORD_BITS+1:0]   p_t    [sbot_pkg::NUM_AXES];
    logic signed [COORD_BITS+1:0]   p_absd [sbot_pkg::NUM_AXES];
    logic                           m_axis_sep;
    logic signed [2*COORD_BITS+2:0] m_pa   [sbot_pkg::NUM_AXES];
    logic signed [2*COORD_BITS+2:0] m_pb   [sbot_pkg::NUM_AXES];
    logic signed [2*COORD_BITS+2:0] m_pe   [sbot_pkg::NUM_AXES];
    logic signed [2*COORD_BITS+2:0] m_pf   [sbot_pkg::NUM_AXES];
    logic                           hit;

    // ------------------------------------------------------------------
    // configuration: always ready, index past the last register ignored
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < sbot_pkg::NUM_AXES; a++) begin
                r_lower[a] <= '0;
                r_upper[a] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sbot_pkg::REG_BOX_LOWER_X: r_lower[0] <= i_cfg_data;
                sbot_pkg::REG_BOX_UPPER_X: r_upper[0] <= i_cfg_data;
                sbot_pkg::REG_BOX_LOWER_Y: r_lower[1] <= i_cfg_data;
                sbot_pkg::REG_BOX_UPPER_Y: r_upper[1] <= i_cfg_data;
                sbot_pkg::REG_BOX_LOWER_Z: r_lower[2] <= i_cfg_data;
                sbot_pkg::REG_BOX_UPPER_Z: r_upper[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage advances when empty or when the next
    // stage advances; the output register advances on m_axis_tready
    // ------------------------------------------------------------------
    always_comb begin
        stage_en[NS-1] = ~r_vld[NS-1] | m_axis_tready;
        for (int s = NS - 2; s >= 0; s--) begin
            stage_en[s] = ~r_vld[s] | stage_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < NS; s++) begin
                if (stage_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign s_axis_tready = stage_en[0];

    // unpack the input transaction
    always_comb begin
        for (int a = 0; a < sbot_pkg::NUM_AXES; a++) begin
            seg_start[a] = s_axis_tdata[a * COORD_BITS +: COORD_BITS];
            seg_end[a]   = s_axis_tdata[(a + sbot_pkg::NUM_AXES) * COORD_BITS +: COORD_BITS];
        end
    end

    // stages 1-2: differences, sums, magnitudes
    sbot_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_en    (stage_en[1:0]),
        .i_start (seg_start),
        .i_end   (seg_end),
        .i_lower (r_lower),
        .i_upper (r_upper),
        .o_d     (p_d),
        .o_e     (p_e),
        .o_t     (p_t),
        .o_absd  (p_absd)
    );

    // stage 3: box-axis tests and cross products
    sbot_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_en       (stage_en[2]),
        .i_d        (p_d),
        .i_e        (p_e),
        .i_t        (p_t),
        .i_absd     (p_absd),
        .o_axis_sep (m_axis_sep),
        .o_pa       (m_pa),
        .o_pb       (m_pb),
        .o_pe       (m_pe),
        .o_pf       (m_pf)
    );

    // stages 4-5: cross-axis compares, result register
    sbot_dec #(
        .COORD_BITS (COORD_BITS)
    ) u_dec (
        .i_clk      (i_clk),
        .i_en       (stage_en[4:3]),
        .i_axis_sep (m_axis_sep),
        .i_pa       (m_pa),
        .i_pb       (m_pb),
        .i_pe       (m_pe),
        .i_pf       (m_pf),
        .o_hit      (hit)
    );

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {{(sbot_pkg::M_TDATA_W - 1){1'b0}}, hit};

endmodule
